// File: sv/psf_pkg.sv
// Shared constants, codes and types of the pose smoothing filter.
package psf_pkg;

    // operation codes of an input request
    localparam logic [1:0] OP_POSITION = 2'd0;
    localparam logic [1:0] OP_ROTATION = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_POS_GAIN = 2'd0;
    localparam logic [1:0] REG_ROT_GAIN = 2'd1;
    localparam logic [1:0] REG_VEL_GAIN = 2'd2;

    localparam int GAIN_W = 17;
    localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32768;
    localparam logic signed [15:0] Q14_ONE   = 16'sd16384;
    localparam int MS_PER_S = 1000;

    // divide / square root unit sizes
    localparam int DIVIDEND_W = 44;  // quotient width as well
    localparam int DIVISOR_W  = 26;
    localparam int RADICAND_W = 52;
    localparam int ROOT_W     = RADICAND_W / 2;
    localparam int REM_W      = 28;
    localparam int CNT_W      = 6;

    typedef logic signed [31:0] pos_t;
    typedef logic signed [15:0] quat_t;

    typedef struct packed {
        logic                  start;
        logic                  is_sqrt;
        logic [RADICAND_W-1:0] operand;   // radicand, or dividend in the low bits
        logic [DIVISOR_W-1:0]  divisor;
    } iter_cmd_t;

    typedef struct packed {
        logic                  busy;
        logic [DIVIDEND_W-1:0] result;    // quotient, or root in the low bits
    } iter_stat_t;

endpackage

// File: sv/psf_sample_if.sv
// Input request channel: operation and new pose sample.
interface psf_sample_if;
    import psf_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    pos_t        pos_x;
    pos_t        pos_y;
    pos_t        pos_z;
    quat_t       rot_w;
    quat_t       rot_x;
    quat_t       rot_y;
    quat_t       rot_z;
    logic [15:0] elapsed_ms;

    modport source (output valid, operation, pos_x, pos_y, pos_z,
                    rot_w, rot_x, rot_y, rot_z, elapsed_ms, input ready);
    modport sink   (input valid, operation, pos_x, pos_y, pos_z,
                    rot_w, rot_x, rot_y, rot_z, elapsed_ms, output ready);
endinterface

// File: sv/psf_pose_if.sv
// Result request channel: smoothed pose and velocity.
interface psf_pose_if;
    import psf_pkg::*;

    logic  valid;
    logic  ready;
    pos_t  out_pos_x;
    pos_t  out_pos_y;
    pos_t  out_pos_z;
    quat_t out_rot_w;
    quat_t out_rot_x;
    quat_t out_rot_y;
    quat_t out_rot_z;
    pos_t  out_vel_x;
    pos_t  out_vel_y;
    pos_t  out_vel_z;

    modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_rot_w, out_rot_x,
                    out_rot_y, out_rot_z, out_vel_x, out_vel_y, out_vel_z, input ready);
    modport sink   (input valid, out_pos_x, out_pos_y, out_pos_z, out_rot_w, out_rot_x,
                    out_rot_y, out_rot_z, out_vel_x, out_vel_y, out_vel_z, output ready);
endinterface

// File: sv/psf_iter.sv
// Shared bit-serial unit: restoring division or digit-by-digit square root.
module psf_iter (
    input  logic                clk,
    input  logic                rst_n,
    input  psf_pkg::iter_cmd_t  cmd,
    output psf_pkg::iter_stat_t stat
);
    import psf_pkg::*;

    logic                  busy_reg;
    logic                  sqrt_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [RADICAND_W-1:0] opd_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [DIVIDEND_W-1:0] res_reg;
    logic [DIVISOR_W-1:0]  div_reg;

    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    // one quotient or root digit per cycle
    always_comb
    begin
        if (sqrt_reg)
        begin
            rem2  = {rem_reg, opd_reg[RADICAND_W-1 -: 2]};
            trial = {2'b00, res_reg[ROOT_W-1:0], 2'b01};
        end
        else
        begin
            rem2  = {1'b0, rem_reg, opd_reg[RADICAND_W-1]};
            trial = (REM_W+2)'(div_reg);
        end
        ge   = (rem2 >= trial);
        diff = rem2 - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= cmd.is_sqrt ? CNT_W'(ROOT_W) : CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (cmd.start && !busy_reg)
        begin
            sqrt_reg <= cmd.is_sqrt;
            div_reg  <= cmd.divisor;
            rem_reg  <= '0;
            res_reg  <= '0;
            if (cmd.is_sqrt)
                opd_reg <= cmd.operand;
            else
                opd_reg <= {cmd.operand[DIVIDEND_W-1:0], (RADICAND_W-DIVIDEND_W)'(0)};
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
            res_reg <= {res_reg[DIVIDEND_W-2:0], ge};
            opd_reg <= sqrt_reg ? (opd_reg << 2) : (opd_reg << 1);
        end
    end

    assign stat.busy   = busy_reg;
    assign stat.result = res_reg;

endmodule

// File: sv/pose_smoothing_filter.sv
// Request handling: position, rotation and frame tick (frame tick goes straight
// to the output when elapsed time is zero); one request at a time.
// The bit-serial divide / square root unit works one digit per cycle.
// A finished pose waits in an output register while the next request is taken.
// Reset: asynchronous, active low; gains to one half, pose and velocity to
// zero, rotation to identity.
module pose_smoothing_filter (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [psf_pkg::GAIN_W-1:0] cfg_wr_data,
    psf_sample_if.sink              sample,
    psf_pose_if.source              pose
);
    import psf_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_PMUL   = 5'd1;
    localparam logic [4:0] S_PACC   = 5'd2;
    localparam logic [4:0] S_RDOT   = 5'd3;
    localparam logic [4:0] S_RDACC  = 5'd4;
    localparam logic [4:0] S_RBL    = 5'd5;
    localparam logic [4:0] S_RBACC  = 5'd6;
    localparam logic [4:0] S_RSQ    = 5'd7;
    localparam logic [4:0] S_RSQACC = 5'd8;
    localparam logic [4:0] S_RSQRT  = 5'd9;
    localparam logic [4:0] S_RSQW   = 5'd10;
    localparam logic [4:0] S_RDIV   = 5'd11;
    localparam logic [4:0] S_RDIVW  = 5'd12;
    localparam logic [4:0] S_VMUL   = 5'd13;
    localparam logic [4:0] S_VDIV   = 5'd14;
    localparam logic [4:0] S_VDIVW  = 5'd15;
    localparam logic [4:0] S_VMH    = 5'd16;
    localparam logic [4:0] S_VACCH  = 5'd17;
    localparam logic [4:0] S_VML    = 5'd18;
    localparam logic [4:0] S_VACCL  = 5'd19;
    localparam logic [4:0] S_OUT    = 5'd20;

    logic [4:0]        state_reg;
    logic [1:0]        idx_reg;
    logic [GAIN_W-1:0] pgain_reg, rgain_reg, vgain_reg;
    logic [GAIN_W-1:0] pgain, rgain, vgain;

    pos_t  tpos_reg [3];
    pos_t  epos_reg [3];
    pos_t  evel_reg [3];
    quat_t trot_reg [4];
    pos_t  npos_reg [3];
    quat_t nrot_reg [4];
    logic [15:0] dt_reg;

    logic signed [63:0] acc_reg;
    logic signed [60:0] prod_reg;
    logic signed [25:0] b_reg [4];
    logic [51:0]        sum_reg;
    logic [ROOT_W-1:0]  mag_reg;
    logic               neg_reg;
    logic               vsgn_reg;
    logic signed [45:0] dv_reg;
    logic               out_valid_reg;

    logic signed [26:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [16:0] o_sel;
    logic signed [63:0] dot_sum;
    logic signed [63:0] blend_v;
    logic signed [47:0] vel_r;
    logic [60:0]        prod_abs;
    logic [25:0]        b_abs;
    logic [DIVIDEND_W-1:0] quo;
    logic [14:0]        c_mag;
    logic signed [45:0] raw;
    pos_t               vel_sat;
    logic               accept;

    iter_cmd_t  it_cmd;
    iter_stat_t it_stat;

    psf_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (it_cmd),
        .stat  (it_stat)
    );

    // gains above one act as one
    assign pgain = (pgain_reg > GAIN_ONE) ? GAIN_ONE : pgain_reg;
    assign rgain = (rgain_reg > GAIN_ONE) ? GAIN_ONE : rgain_reg;
    assign vgain = (vgain_reg > GAIN_ONE) ? GAIN_ONE : vgain_reg;

    assign sample.ready = (state_reg == S_IDLE);
    assign accept       = sample.valid && sample.ready;

    // old rotation, sign flipped on a negative dot product
    assign o_sel = neg_reg ? -(17'(trot_reg[idx_reg])) : 17'(trot_reg[idx_reg]);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PMUL:
            begin
                mul_a = $signed({10'b0, pgain});
                mul_b = 34'(npos_reg[idx_reg]) - 34'(tpos_reg[idx_reg]);
            end
            S_RDOT:
            begin
                mul_a = 27'(nrot_reg[idx_reg]);
                mul_b = 34'(trot_reg[idx_reg]);
            end
            S_RBL:
            begin
                mul_a = $signed({10'b0, rgain});
                mul_b = 34'(nrot_reg[idx_reg]) - 34'(o_sel);
            end
            S_RSQ:
            begin
                mul_a = 27'(b_reg[idx_reg]);
                mul_b = 34'(b_reg[idx_reg]);
            end
            S_VMUL:
            begin
                mul_a = 27'(MS_PER_S);
                mul_b = 34'(tpos_reg[idx_reg]) - 34'(epos_reg[idx_reg]);
            end
            S_VMH:
            begin
                mul_a = $signed({10'b0, vgain});
                mul_b = 34'($signed(dv_reg[45:33]));
            end
            S_VML:
            begin
                mul_a = $signed({10'b0, vgain});
                mul_b = $signed({1'b0, dv_reg[32:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // accumulate, round and clamp helpers
    always_comb
    begin
        dot_sum  = acc_reg + 64'(prod_reg);
        prod_abs = prod_reg[60] ? 61'(-prod_reg) : 61'(prod_reg);
        b_abs    = b_reg[idx_reg][25] ? 26'(-b_reg[idx_reg]) : 26'(b_reg[idx_reg]);
        quo      = it_stat.result;
        c_mag    = (quo > DIVIDEND_W'(Q14_ONE)) ? 15'(Q14_ONE) : quo[14:0];
        raw      = vsgn_reg ? -(46'(quo)) : 46'(quo);
        case (state_reg)
            S_PACC:  blend_v = (64'(tpos_reg[idx_reg]) <<< 16) + 64'(prod_reg) + 64'sd32768;
            S_RBACC: blend_v = (64'(o_sel) <<< 16) + 64'(prod_reg) + 64'sd128;
            default: blend_v = acc_reg + 64'(prod_reg) + 64'sd32768;
        endcase
        vel_r = blend_v[63:16];
        if (vel_r > 48'sh7FFF_FFFF)
            vel_sat = 32'sh7FFF_FFFF;
        else if (vel_r < -48'sh8000_0000)
            vel_sat = 32'sh8000_0000;
        else
            vel_sat = vel_r[31:0];
    end

    // divide / square root commands
    always_comb
    begin
        it_cmd.start   = 1'b0;
        it_cmd.is_sqrt = 1'b0;
        it_cmd.operand = '0;
        it_cmd.divisor = '0;
        case (state_reg)
            S_RSQRT:
            begin
                it_cmd.start   = 1'b1;
                it_cmd.is_sqrt = 1'b1;
                it_cmd.operand = sum_reg;
            end
            S_RDIV:
            begin
                it_cmd.start   = 1'b1;
                it_cmd.operand = RADICAND_W'(DIVIDEND_W'({b_abs, 14'b0})
                                 + DIVIDEND_W'(mag_reg >> 1));
                it_cmd.divisor = mag_reg;
            end
            S_VDIV:
            begin
                it_cmd.start   = 1'b1;
                it_cmd.operand = RADICAND_W'(prod_abs[DIVIDEND_W-1:0]
                                 + DIVIDEND_W'(dt_reg >> 1));
                it_cmd.divisor = DIVISOR_W'(dt_reg);
            end
            default:
            begin
                it_cmd.start = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pgain_reg <= GAIN_RESET;
            rgain_reg <= GAIN_RESET;
            vgain_reg <= GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_POS_GAIN: pgain_reg <= cfg_wr_data;
                REG_ROT_GAIN: rgain_reg <= cfg_wr_data;
                REG_VEL_GAIN: vgain_reg <= cfg_wr_data;
                default:      pgain_reg <= pgain_reg;
            endcase
        end
    end

    // multiplier output register and request latch
    always_ff @(posedge clk)
    begin
        prod_reg <= 61'(mul_a * mul_b);
        if (accept)
        begin
            npos_reg[0] <= sample.pos_x;
            npos_reg[1] <= sample.pos_y;
            npos_reg[2] <= sample.pos_z;
            nrot_reg[0] <= sample.rot_w;
            nrot_reg[1] <= sample.rot_x;
            nrot_reg[2] <= sample.rot_y;
            nrot_reg[3] <= sample.rot_z;
            dt_reg      <= sample.elapsed_ms;
        end
    end

    // sequencer and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            sum_reg       <= '0;
            neg_reg       <= 1'b0;
            vsgn_reg      <= 1'b0;
            mag_reg       <= '0;
            dv_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                tpos_reg[i] <= '0;
                epos_reg[i] <= '0;
                evel_reg[i] <= '0;
            end
            trot_reg[0] <= Q14_ONE;
            trot_reg[1] <= '0;
            trot_reg[2] <= '0;
            trot_reg[3] <= '0;
            for (int i = 0; i < 4; i++)
                b_reg[i] <= '0;
        end
        else
        begin
            // the output state reloads the register itself
            if (pose.valid && pose.ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    acc_reg <= '0;
                    sum_reg <= '0;
                    if (accept)
                    begin
                        case (sample.operation)
                            OP_POSITION: state_reg <= S_PMUL;
                            OP_ROTATION: state_reg <= S_RDOT;
                            OP_TICK:
                                state_reg <= (sample.elapsed_ms == 16'd0) ? S_OUT : S_VMUL;
                            default:     state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_PMUL: state_reg <= S_PACC;
                S_PACC:
                begin
                    tpos_reg[idx_reg] <= blend_v[47:16];
                    idx_reg           <= idx_reg + 1'b1;
                    state_reg         <= (idx_reg == 2'd2) ? S_IDLE : S_PMUL;
                end
                S_RDOT: state_reg <= S_RDACC;
                S_RDACC:
                begin
                    acc_reg <= dot_sum;
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == 2'd3)
                    begin
                        neg_reg   <= dot_sum[63];
                        state_reg <= S_RBL;
                    end
                    else
                        state_reg <= S_RDOT;
                end
                S_RBL: state_reg <= S_RBACC;
                S_RBACC:
                begin
                    b_reg[idx_reg] <= blend_v[33:8];
                    state_reg      <= S_RSQ;
                end
                S_RSQ: state_reg <= S_RSQACC;
                S_RSQACC:
                begin
                    sum_reg   <= sum_reg + prod_reg[51:0];
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= (idx_reg == 2'd3) ? S_RSQRT : S_RBL;
                end
                S_RSQRT: state_reg <= S_RSQW;
                S_RSQW:
                begin
                    if (!it_stat.busy)
                    begin
                        mag_reg <= it_stat.result[ROOT_W-1:0];
                        idx_reg <= '0;
                        // zero length keeps the old rotation
                        state_reg <= (it_stat.result[ROOT_W-1:0] == '0) ? S_IDLE : S_RDIV;
                    end
                end
                S_RDIV: state_reg <= S_RDIVW;
                S_RDIVW:
                begin
                    if (!it_stat.busy)
                    begin
                        trot_reg[idx_reg] <= b_reg[idx_reg][25] ? -(16'(c_mag)) : 16'(c_mag);
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= (idx_reg == 2'd3) ? S_IDLE : S_RDIV;
                    end
                end
                S_VMUL: state_reg <= S_VDIV;
                S_VDIV:
                begin
                    vsgn_reg  <= prod_reg[60];
                    state_reg <= S_VDIVW;
                end
                S_VDIVW:
                begin
                    if (!it_stat.busy)
                    begin
                        dv_reg    <= raw - 46'(evel_reg[idx_reg]);
                        state_reg <= S_VMH;
                    end
                end
                S_VMH: state_reg <= S_VACCH;
                S_VACCH:
                begin
                    acc_reg   <= (64'(evel_reg[idx_reg]) <<< 16) + (64'(prod_reg) <<< 33);
                    state_reg <= S_VML;
                end
                S_VML: state_reg <= S_VACCL;
                S_VACCL:
                begin
                    evel_reg[idx_reg] <= vel_sat;
                    idx_reg           <= idx_reg + 1'b1;
                    state_reg         <= (idx_reg == 2'd2) ? S_OUT : S_VMUL;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || pose.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        for (int i = 0; i < 3; i++)
                            epos_reg[i] <= tpos_reg[i];
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!out_valid_reg || pose.ready))
        begin
            pose.out_pos_x <= tpos_reg[0];
            pose.out_pos_y <= tpos_reg[1];
            pose.out_pos_z <= tpos_reg[2];
            pose.out_rot_w <= trot_reg[0];
            pose.out_rot_x <= trot_reg[1];
            pose.out_rot_y <= trot_reg[2];
            pose.out_rot_z <= trot_reg[3];
            pose.out_vel_x <= evel_reg[0];
            pose.out_vel_y <= evel_reg[1];
            pose.out_vel_z <= evel_reg[2];
        end
    end

    assign pose.valid = out_valid_reg;

    // the shared unit is never restarted while it works
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        it_cmd.start |-> !it_stat.busy)
        else $error("divide/sqrt unit started while busy");

    // a new request is only taken with the shared unit free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> !it_stat.busy)
        else $error("request taken while unit busy");

    // an unused operation leaves the block idle
    a_op_none: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample.operation == OP_NONE) |=> state_reg == S_IDLE)
        else $error("unused operation started work");

    // a result appears only out of the output state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    // stored rotation stays within unit range
    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (trot_reg[0] <= Q14_ONE && trot_reg[0] >= -Q14_ONE &&
         trot_reg[1] <= Q14_ONE && trot_reg[1] >= -Q14_ONE &&
         trot_reg[2] <= Q14_ONE && trot_reg[2] >= -Q14_ONE &&
         trot_reg[3] <= Q14_ONE && trot_reg[3] >= -Q14_ONE))
        else $error("rotation component out of range");

endmodule
